FILE: hw/rtl/stun_pkg.sv
// Shared types, constants and the exp(-x) lookup table for the STUN acceptance step.
package stun_pkg;

  localparam int EXP_TABLE_ENTRIES = 64;
  localparam int TAB_W   = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int VAL_W   = 17;   // table values span 0..65536
  localparam int MUL_W   = 20;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int FRAC_W  = 20;

  localparam logic [1:0] OUTCOME_REJECT   = 2'd0;
  localparam logic [1:0] OUTCOME_DOWNHILL = 2'd1;
  localparam logic [1:0] OUTCOME_TUNNEL   = 2'd2;
  localparam logic [1:0] OUTCOME_START    = 2'd3;

  localparam logic KIND_START     = 1'b0;
  localparam logic KIND_CANDIDATE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] candidate_energy;
    logic [15:0] inverse_temperature;
    logic [15:0] random_sample;
  } stun_in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic        new_best;
    logic [15:0] target_tunnel_value;
    logic [15:0] lowest_energy;
  } stun_out_t;

  typedef logic [EXP_TABLE_ENTRIES:0][VAL_W-1:0] exp_tab_t;

  typedef struct packed {
    logic [MUL_W-1:0] op_a;
    logic [MUL_W-1:0] op_b;
    logic [TAB_W-1:0] tab_idx;
  } stun_arith_req_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [VAL_W-1:0]  tab_hi;
    logic [VAL_W-1:0]  tab_span;
  } stun_arith_rsp_t;

  // exp(-16/N) in Q2.30 by truncated Taylor series, then repeated rounded products
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t                tab;
    logic [63:0]             t;
    logic [63:0]             term;
    logic [63:0]             p;
    logic [63:0]             r;
    longint                  sum;
    t    = (64'd16 << 30) / EXP_TABLE_ENTRIES;
    term = 64'd1 << 30;
    sum  = longint'(64'd1 << 30);
    for (int k = 1; k <= 24; k++) begin
      term = ((term * t) >> 30) / 64'(k);
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(64'd1 << 30)) sum = longint'(64'd1 << 30);
    r = 64'(sum);
    p = 64'd1 << 30;
    tab[0] = VAL_W'(65536);
    for (int i = 1; i <= EXP_TABLE_ENTRIES; i++) begin
      p = (p * r + (64'd1 << 29)) >> 30;
      tab[i] = VAL_W'((p + (64'd1 << 13)) >> 14);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

FILE: hw/rtl/stun_arith.sv
// Shared multiplier and exp table lookup used by every arithmetic step of the sequencer.
module stun_arith (
  input  stun_pkg::stun_arith_req_t req,
  output stun_pkg::stun_arith_rsp_t rsp
);

  logic [stun_pkg::TAB_W-1:0] idx_next;
  logic [stun_pkg::VAL_W-1:0] tab_a;
  logic [stun_pkg::VAL_W-1:0] tab_b;

  assign idx_next = req.tab_idx + stun_pkg::TAB_W'(1);
  assign tab_a    = stun_pkg::EXP_TAB[req.tab_idx];
  assign tab_b    = stun_pkg::EXP_TAB[idx_next];

  always_comb begin
    rsp.prod     = stun_pkg::PROD_W'(req.op_a) * stun_pkg::PROD_W'(req.op_b);
    rsp.tab_hi   = tab_a;
    // table is monotone, but clamp so the span never wraps
    rsp.tab_span = (tab_b > tab_a) ? '0 : tab_a - tab_b;
  end

endmodule

FILE: hw/rtl/stun_acceptance_step_unit.sv
// Top level of the stochastic tunneling Metropolis acceptance step.
//
// One item is in flight at a time; in_stall is high from the cycle after a
// transfer until the result has been loaded into the output register. A start
// item, or a downhill candidate that is not a new best, goes straight to the
// final state. A new best runs gamma*diff, table position and interpolation
// (only gamma*diff when the tunneling exponent saturates). Any other candidate
// runs up to every step (gamma*diff, table position, interpolation, temp*delta,
// position, interpolation) on the one 20x20 multiplier in stun_arith, one step per
// cycle. A result waiting on out_stall holds the sequencer in its final state.
// Configuration writes must only happen while no item is in flight.
module stun_acceptance_step_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  stun_pkg::stun_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output stun_pkg::stun_out_t out_data,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TMUL = 3'd1;
  localparam logic [2:0] S_AMUL = 3'd2;
  localparam logic [2:0] S_POS  = 3'd3;
  localparam logic [2:0] S_INT  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [stun_pkg::PROD_W-1:0] RND_HALF =
    stun_pkg::PROD_W'(1) << (stun_pkg::FRAC_W - 1);

  logic [2:0]  state_r, state_nxt;
  logic [15:0] gamma_r;
  logic [15:0] cur_e_r, cur_e_nxt;
  logic [15:0] low_e_r, low_e_nxt;
  logic [15:0] cur_s_r, cur_s_nxt;
  logic        out_valid_r;
  stun_pkg::stun_out_t out_data_r;

  logic [15:0] e_r, e_nxt;
  logic [15:0] temp_r, temp_nxt;
  logic [15:0] sample_r, sample_nxt;
  logic [15:0] diff_r, diff_nxt;
  logic [15:0] ts_r, ts_nxt;
  logic [stun_pkg::MUL_W-1:0]  x_r, x_nxt;
  logic [stun_pkg::TAB_W-1:0]  idx_r, idx_nxt;
  logic [stun_pkg::FRAC_W-1:0] frac_r, frac_nxt;
  logic        phase_r, phase_nxt;   // 0 tunneling value, 1 acceptance probability
  logic        down_r, down_nxt;     // tunneling value belongs to a new best
  logic [1:0]  res_outcome_r, res_outcome_nxt;
  logic        res_best_r, res_best_nxt;
  logic [15:0] res_ts_r, res_ts_nxt;

  stun_pkg::stun_arith_req_t arith_req;
  stun_pkg::stun_arith_rsp_t arith_rsp;

  logic [stun_pkg::PROD_W-1:0] rnd;
  logic [stun_pkg::VAL_W-1:0]  interp_v;
  logic                        tun_fin;
  logic [15:0]                 tun_s;
  logic                        acc_fin;
  logic [stun_pkg::VAL_W-1:0]  acc_pr;
  logic                        out_load;

  stun_arith u_arith (
    .req (arith_req),
    .rsp (arith_rsp)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign rnd      = arith_rsp.prod + RND_HALF;
  assign interp_v = arith_rsp.tab_hi - rnd[stun_pkg::FRAC_W +: stun_pkg::VAL_W];

  // operand select for the shared multiplier
  always_comb begin
    arith_req.op_a    = '0;
    arith_req.op_b    = '0;
    arith_req.tab_idx = idx_r;
    unique case (state_r)
      S_TMUL: begin
        arith_req.op_a = stun_pkg::MUL_W'(gamma_r);
        arith_req.op_b = stun_pkg::MUL_W'(diff_r);
      end
      S_AMUL: begin
        arith_req.op_a = stun_pkg::MUL_W'(temp_r);
        arith_req.op_b = stun_pkg::MUL_W'(ts_r - cur_s_r);
      end
      S_POS: begin
        arith_req.op_a = x_r;
        arith_req.op_b = stun_pkg::MUL_W'(stun_pkg::EXP_TABLE_ENTRIES);
      end
      S_INT: begin
        arith_req.op_a = stun_pkg::MUL_W'(arith_rsp.tab_span);
        arith_req.op_b = frac_r;
      end
      default: begin
        arith_req.op_a = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    cur_e_nxt       = cur_e_r;
    low_e_nxt       = low_e_r;
    cur_s_nxt       = cur_s_r;
    e_nxt           = e_r;
    temp_nxt        = temp_r;
    sample_nxt      = sample_r;
    diff_nxt        = diff_r;
    ts_nxt          = ts_r;
    x_nxt           = x_r;
    idx_nxt         = idx_r;
    frac_nxt        = frac_r;
    phase_nxt       = phase_r;
    down_nxt        = down_r;
    res_outcome_nxt = res_outcome_r;
    res_best_nxt    = res_best_r;
    res_ts_nxt      = res_ts_r;
    tun_fin         = 1'b0;
    tun_s           = '0;
    acc_fin         = 1'b0;
    acc_pr          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          e_nxt      = in_data.candidate_energy;
          temp_nxt   = in_data.inverse_temperature;
          sample_nxt = in_data.random_sample;
          res_ts_nxt = '0;
          if (in_data.kind == stun_pkg::KIND_START) begin
            cur_e_nxt       = in_data.candidate_energy;
            low_e_nxt       = in_data.candidate_energy;
            cur_s_nxt       = '0;
            res_outcome_nxt = stun_pkg::OUTCOME_START;
            res_best_nxt    = 1'b1;
            state_nxt       = S_DONE;
          end else if (in_data.candidate_energy < cur_e_r) begin
            cur_e_nxt       = in_data.candidate_energy;
            res_outcome_nxt = stun_pkg::OUTCOME_DOWNHILL;
            if (in_data.candidate_energy < low_e_r) begin
              // new best: s is rebuilt from the old current energy
              low_e_nxt    = in_data.candidate_energy;
              diff_nxt     = cur_e_r - in_data.candidate_energy;
              down_nxt     = 1'b1;
              res_best_nxt = 1'b1;
              state_nxt    = S_TMUL;
            end else begin
              res_best_nxt = 1'b0;
              state_nxt    = S_DONE;
            end
          end else begin
            diff_nxt     = (in_data.candidate_energy > low_e_r) ?
                           in_data.candidate_energy - low_e_r : '0;
            down_nxt     = 1'b0;
            res_best_nxt = 1'b0;
            state_nxt    = S_TMUL;
          end
        end
      end
      S_TMUL: begin
        if (arith_rsp.prod[31:24] != '0) begin
          tun_fin = 1'b1;
          tun_s   = 16'hFFFF;
        end else begin
          x_nxt     = arith_rsp.prod[23:4];
          phase_nxt = 1'b0;
          state_nxt = S_POS;
        end
      end
      S_AMUL: begin
        if (arith_rsp.prod[31:28] != '0) begin
          acc_fin = 1'b1;
          acc_pr  = '0;
        end else begin
          x_nxt     = arith_rsp.prod[27:8];
          phase_nxt = 1'b1;
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        idx_nxt   = arith_rsp.prod[stun_pkg::FRAC_W +: stun_pkg::TAB_W];
        frac_nxt  = arith_rsp.prod[stun_pkg::FRAC_W-1:0];
        state_nxt = S_INT;
      end
      S_INT: begin
        if (phase_r) begin
          acc_fin = 1'b1;
          acc_pr  = interp_v;
        end else begin
          tun_fin = 1'b1;
          tun_s   = (interp_v == '0) ? 16'hFFFF :
                    16'(stun_pkg::VAL_W'(65536) - interp_v);
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (tun_fin) begin
      if (down_r) begin
        cur_s_nxt = tun_s;
        state_nxt = S_DONE;
      end else begin
        ts_nxt     = tun_s;
        res_ts_nxt = tun_s;
        if (tun_s <= cur_s_r) begin
          acc_fin = 1'b1;
          acc_pr  = stun_pkg::VAL_W'(65536);
        end else begin
          state_nxt = S_AMUL;
        end
      end
    end

    if (acc_fin) begin
      if (acc_pr >= stun_pkg::VAL_W'(sample_r)) begin
        cur_e_nxt       = e_r;
        cur_s_nxt       = ts_nxt;
        res_outcome_nxt = stun_pkg::OUTCOME_TUNNEL;
      end else begin
        res_outcome_nxt = stun_pkg::OUTCOME_REJECT;
      end
      state_nxt = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gamma_r     <= 16'd256;
      cur_e_r     <= '0;
      low_e_r     <= '0;
      cur_s_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_e_r <= cur_e_nxt;
      low_e_r <= low_e_nxt;
      cur_s_r <= cur_s_nxt;
      if (cfg_wr_en) gamma_r <= cfg_wr_data;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    e_r           <= e_nxt;
    temp_r        <= temp_nxt;
    sample_r      <= sample_nxt;
    diff_r        <= diff_nxt;
    ts_r          <= ts_nxt;
    x_r           <= x_nxt;
    idx_r         <= idx_nxt;
    frac_r        <= frac_nxt;
    phase_r       <= phase_nxt;
    down_r        <= down_nxt;
    res_outcome_r <= res_outcome_nxt;
    res_best_r    <= res_best_nxt;
    res_ts_r      <= res_ts_nxt;
    if (out_load) begin
      out_data_r.outcome             <= res_outcome_r;
      out_data_r.new_best            <= res_best_r;
      out_data_r.target_tunnel_value <= res_ts_r;
      out_data_r.lowest_energy       <= low_e_r;
    end
  end

endmodule
